FILE: rtl/core/sbfi_pkg.sv
// shared types, constants and gf(2^8) helpers for the aes s-box block
// no dependencies; used by sbfi_core and aes_sbox_forward_inverse
package sbfi_pkg;

  typedef logic [7:0] byte_t;
  typedef byte_t byte_tbl_t [256];

  localparam byte_t POLY_LOW = 8'h1b;
  localparam byte_t AFFINE_C = 8'h63;
  localparam byte_t INV_EXP  = 8'hfe;

  // multiply modulo x^8+x^4+x^3+x+1
  function automatic byte_t gf_mul(byte_t a, byte_t b);
    logic [8:0] x;
    byte_t      y;
    byte_t      acc;
    x   = {1'b0, a};
    y   = b;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (y[0]) begin
        acc = acc ^ x[7:0];
      end
      y = y >> 1;
      x = x << 1;
      if (x[8]) begin
        x = {1'b0, x[7:0] ^ POLY_LOW};
      end
    end
    return acc;
  endfunction

  // a^254, zero maps to zero
  function automatic byte_t gf_inv_calc(byte_t a);
    byte_t res;
    byte_t base;
    res  = 8'h01;
    base = a;
    for (int k = 0; k < 8; k++) begin
      if (INV_EXP[k]) begin
        res = gf_mul(res, base);
      end
      base = gf_mul(base, base);
    end
    return res;
  endfunction

  function automatic byte_tbl_t gen_gf_inv_tbl();
    byte_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = gf_inv_calc(byte_t'(i));
    end
    return t;
  endfunction

  // built at elaboration, synthesizes to a constant rom
  localparam byte_tbl_t GF_INV_TBL = gen_gf_inv_tbl();

  function automatic byte_t rotl(byte_t v, int unsigned n);
    byte_t r;
    r = v;
    for (int k = 0; k < 8; k++) begin
      if (k < n) begin
        r = {r[6:0], r[7]};
      end
    end
    return r;
  endfunction

  function automatic byte_t fwd_affine(byte_t b);
    return b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ AFFINE_C;
  endfunction

  function automatic byte_t inv_affine(byte_t v);
    byte_t c;
    c = v ^ AFFINE_C;
    return rotl(c, 1) ^ rotl(c, 3) ^ rotl(c, 6);
  endfunction

endpackage

FILE: rtl/core/sbfi_core.sv
// substitution datapath: inverse affine in inverse mode, field inverse rom, forward affine in forward mode
// depends on sbfi_pkg
module sbfi_core (
  input  logic          inverse_mode,
  input  sbfi_pkg::byte_t in_byte,
  output sbfi_pkg::byte_t out_byte
);

  sbfi_pkg::byte_t inv_in;
  sbfi_pkg::byte_t inv_out;

  always_comb begin
    if (inverse_mode) begin
      inv_in = sbfi_pkg::inv_affine(in_byte);
    end else begin
      inv_in = in_byte;
    end
    inv_out = sbfi_pkg::GF_INV_TBL[inv_in];
    if (inverse_mode) begin
      out_byte = inv_out;
    end else begin
      out_byte = sbfi_pkg::fwd_affine(inv_out);
    end
  end

endmodule

FILE: rtl/core/aes_sbox_forward_inverse.sv
// top level of the aes forward / inverse s-box with valid/stall channels
// depends on sbfi_pkg and sbfi_core
//
//   channel  ports                        direction  width
//   input    in_valid in_stall in_byte    in         8
//   result   out_valid out_stall out_byte out        8
//   config   cfg_wr_en cfg_wr_data        in         1
//
// one item per cycle sustained while out_stall is low; an accepted item goes through
// the input register, then the substitution logic into the result register
// the field inverse is a 256-entry constant rom between the two registers
// reset clears both valid flags and sets forward mode
// a stall on the result side holds the result register and backs up into in_stall
module aes_sbox_forward_inverse (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte
);

  logic            inverse_mode_r;
  logic            s1_valid_r;
  logic            s1_valid_nxt;
  sbfi_pkg::byte_t s1_byte_r;
  logic            out_valid_r;
  logic            out_valid_nxt;
  sbfi_pkg::byte_t out_byte_r;
  sbfi_pkg::byte_t sub_byte;
  logic            out_ready;
  logic            s1_ready;
  logic            in_take;
  logic            s1_move;

  sbfi_core u_core (
    .inverse_mode (inverse_mode_r),
    .in_byte      (s1_byte_r),
    .out_byte     (sub_byte)
  );

  always_comb begin
    out_ready     = !out_valid_r || !out_stall;
    s1_ready      = !s1_valid_r || out_ready;
    in_take       = in_valid && s1_ready;
    s1_move       = s1_valid_r && out_ready;
    s1_valid_nxt  = in_take || (s1_valid_r && !out_ready);
    out_valid_nxt = s1_move || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inverse_mode_r <= 1'b0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        inverse_mode_r <= cfg_wr_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_byte;
    end
    if (s1_move) begin
      out_byte_r <= sub_byte;
    end
  end

  assign in_stall  = !s1_ready;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

endmodule
